FILE: rtl/core/stq_pkg.sv
// Shared types and constants of the sorted timer queue.
package stq_pkg;

    localparam int unsigned TimerSlots = 64;
    localparam int unsigned DataBytes  = 8;
    localparam int unsigned TimeBits   = 48;
    localparam int unsigned TidW       = 32;
    localparam int unsigned TagW       = 8;
    localparam int unsigned DataW      = 64;
    localparam int unsigned LenW       = 4;
    localparam int unsigned PendW      = 7;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_CANCEL = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DLY  = 2'd1,
        ST_FULL     = 2'd2,
        ST_LONG     = 2'd3
    } t_status;

    // Row-wide command broadcast from the controller to every cell.
    typedef enum logic [2:0] {
        CC_HOLD,
        CC_INSERT,
        CC_REMOVE_ID,
        CC_POP,
        CC_CLEAR
    } t_cell_cmd;

    // Per-cell flags returned to the controller.
    typedef struct packed {
        logic used;
        logic id_hit;
        logic due;
    } t_cell_flags;

    // Mask of the valid low bytes of a data word.
    function automatic logic [DataW-1:0] byte_mask(input logic [LenW-1:0] n);
        logic [DataW-1:0] m;
        m = '0;
        for (int b = 0; b < DataW / 8; b++) begin
            if (b < int'(n)) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

FILE: rtl/core/stq_if.sv
// Valid/ready channel interface.
interface stq_if #(
    parameter int unsigned W = 8
) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/stq_cell.sv
// One slot of the sorted timer row.
module stq_cell #(
    parameter int unsigned TIME_BITS = 48
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  stq_pkg::t_cell_cmd          i_cmd,
    input  logic [TIME_BITS-1:0]        i_exp,
    input  logic [stq_pkg::TidW-1:0]    i_tid,
    input  logic [stq_pkg::TagW-1:0]    i_tag,
    input  logic [stq_pkg::DataW-1:0]   i_data,
    input  logic [stq_pkg::LenW-1:0]    i_len,
    input  logic [TIME_BITS-1:0]        i_now,
    // Left neighbour state.
    input  logic                        i_l_used,
    input  logic                        i_l_later,
    input  logic                        i_l_gone,
    input  logic [TIME_BITS-1:0]        i_l_exp,
    input  logic [stq_pkg::TidW-1:0]    i_l_tid,
    input  logic [stq_pkg::TagW-1:0]    i_l_tag,
    input  logic [stq_pkg::DataW-1:0]   i_l_data,
    input  logic [stq_pkg::LenW-1:0]    i_l_len,
    // Right neighbour state.
    input  logic                        i_r_used,
    input  logic [TIME_BITS-1:0]        i_r_exp,
    input  logic [stq_pkg::TidW-1:0]    i_r_tid,
    input  logic [stq_pkg::TagW-1:0]    i_r_tag,
    input  logic [stq_pkg::DataW-1:0]   i_r_data,
    input  logic [stq_pkg::LenW-1:0]    i_r_len,
    output logic                        o_used,
    output logic                        o_later,
    output logic                        o_gone,
    output logic [TIME_BITS-1:0]        o_exp,
    output logic [stq_pkg::TidW-1:0]    o_tid,
    output logic [stq_pkg::TagW-1:0]    o_tag,
    output logic [stq_pkg::DataW-1:0]   o_data,
    output logic [stq_pkg::LenW-1:0]    o_len,
    output stq_pkg::t_cell_flags        o_flags
);
    import stq_pkg::*;

    logic                 r_used;
    logic [TIME_BITS-1:0] r_exp;
    logic [TidW-1:0]      r_tid;
    logic [TagW-1:0]      r_tag;
    logic [DataW-1:0]     r_data;
    logic [LenW-1:0]      r_len;
    logic                 w_later;
    logic                 w_hit;
    logic                 w_gone;

    // The new timer goes ahead of every entry with equal or later expiry.
    assign w_later = r_used && (r_exp >= i_exp);
    assign w_hit   = r_used && (r_tid == i_tid);
    // A removed entry at or left of here shifts the right side down.
    assign w_gone  = i_l_gone || w_hit;

    // Cell update: insert shifts right, remove and pop shift left, clear empties the cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else begin
            case (i_cmd)
                CC_INSERT: begin
                    if (w_later || !r_used) begin
                        if (i_l_later) begin
                            r_used <= i_l_used;
                            r_exp  <= i_l_exp;
                            r_tid  <= i_l_tid;
                            r_tag  <= i_l_tag;
                            r_data <= i_l_data;
                            r_len  <= i_l_len;
                        end else if (i_l_used) begin
                            r_used <= 1'b1;
                            r_exp  <= i_exp;
                            r_tid  <= i_tid;
                            r_tag  <= i_tag;
                            r_data <= i_data;
                            r_len  <= i_len;
                        end
                    end
                end
                CC_REMOVE_ID, CC_POP: begin
                    if ((i_cmd == CC_POP) || w_gone) begin
                        r_used <= i_r_used;
                        r_exp  <= i_r_exp;
                        r_tid  <= i_r_tid;
                        r_tag  <= i_r_tag;
                        r_data <= i_r_data;
                        r_len  <= i_r_len;
                    end
                end
                CC_CLEAR: r_used <= 1'b0;
                default: ;
            endcase
        end
    end

    assign o_used  = r_used;
    assign o_later = w_later;
    assign o_gone  = w_gone;
    assign o_exp   = r_exp;
    assign o_tid   = r_tid;
    assign o_tag   = r_tag;
    assign o_data  = r_data;
    assign o_len   = r_len;
    assign o_flags = '{used: r_used, id_hit: w_hit, due: r_used && (r_exp <= i_now)};

endmodule

FILE: rtl/core/stq_row.sv
// Row of timer cells kept in expiry order, head at cell 0.
module stq_row #(
    parameter int unsigned TIMER_SLOTS = 64,
    parameter int unsigned TIME_BITS   = 48
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  stq_pkg::t_cell_cmd          i_cmd,
    input  logic [TIME_BITS-1:0]        i_exp,
    input  logic [stq_pkg::TidW-1:0]    i_tid,
    input  logic [stq_pkg::TagW-1:0]    i_tag,
    input  logic [stq_pkg::DataW-1:0]   i_data,
    input  logic [stq_pkg::LenW-1:0]    i_len,
    input  logic [TIME_BITS-1:0]        i_now,
    output logic                        o_any_hit,
    output logic                        o_head_due,
    output logic [stq_pkg::TidW-1:0]    o_head_tid,
    output logic [stq_pkg::TagW-1:0]    o_head_tag,
    output logic [stq_pkg::DataW-1:0]   o_head_data,
    output logic [stq_pkg::LenW-1:0]    o_head_len
);
    import stq_pkg::*;

    logic [TIMER_SLOTS:0]       w_used;
    logic [TIMER_SLOTS:0]       w_later;
    logic [TIMER_SLOTS:0]       w_gone;
    logic [TIME_BITS-1:0]       w_exp  [TIMER_SLOTS+1];
    logic [TidW-1:0]            w_tid  [TIMER_SLOTS+1];
    logic [TagW-1:0]            w_tag  [TIMER_SLOTS+1];
    logic [DataW-1:0]           w_data [TIMER_SLOTS+1];
    logic [LenW-1:0]            w_len  [TIMER_SLOTS+1];
    t_cell_flags                w_flags [TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0]     w_hits;

    // Boundary to the left of cell 0 acts as a used, earlier entry.
    assign w_used[0]  = 1'b1;
    assign w_later[0] = 1'b0;
    assign w_gone[0]  = 1'b0;
    assign w_exp[0]   = '0;
    assign w_tid[0]   = '0;
    assign w_tag[0]   = '0;
    assign w_data[0]  = '0;
    assign w_len[0]   = '0;

    // Cell i sits between boundary i (left) and boundary i+1 (own output).
    for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
        logic                 l_used;
        logic                 r_used_in;
        logic [TIME_BITS-1:0] r_exp_in;
        logic [TidW-1:0]      r_tid_in;
        logic [TagW-1:0]      r_tag_in;
        logic [DataW-1:0]     r_data_in;
        logic [LenW-1:0]      r_len_in;

        assign l_used = w_used[i];
        if (i == TIMER_SLOTS - 1) begin : g_end
            assign r_used_in = 1'b0;
            assign r_exp_in  = '0;
            assign r_tid_in  = '0;
            assign r_tag_in  = '0;
            assign r_data_in = '0;
            assign r_len_in  = '0;
        end else begin : g_mid
            assign r_used_in = w_used[i+2];
            assign r_exp_in  = w_exp[i+2];
            assign r_tid_in  = w_tid[i+2];
            assign r_tag_in  = w_tag[i+2];
            assign r_data_in = w_data[i+2];
            assign r_len_in  = w_len[i+2];
        end

        stq_cell #(.TIME_BITS(TIME_BITS)) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cmd    (i_cmd),
            .i_exp    (i_exp),
            .i_tid    (i_tid),
            .i_tag    (i_tag),
            .i_data   (i_data),
            .i_len    (i_len),
            .i_now    (i_now),
            .i_l_used (l_used),
            .i_l_later(w_later[i]),
            .i_l_gone (w_gone[i]),
            .i_l_exp  (w_exp[i]),
            .i_l_tid  (w_tid[i]),
            .i_l_tag  (w_tag[i]),
            .i_l_data (w_data[i]),
            .i_l_len  (w_len[i]),
            .i_r_used (r_used_in),
            .i_r_exp  (r_exp_in),
            .i_r_tid  (r_tid_in),
            .i_r_tag  (r_tag_in),
            .i_r_data (r_data_in),
            .i_r_len  (r_len_in),
            .o_used   (w_used[i+1]),
            .o_later  (w_later[i+1]),
            .o_gone   (w_gone[i+1]),
            .o_exp    (w_exp[i+1]),
            .o_tid    (w_tid[i+1]),
            .o_tag    (w_tag[i+1]),
            .o_data   (w_data[i+1]),
            .o_len    (w_len[i+1]),
            .o_flags  (w_flags[i])
        );
        assign w_hits[i] = w_flags[i].id_hit;
    end

    assign o_any_hit   = |w_hits;
    assign o_head_due  = w_flags[0].due;
    assign o_head_tid  = w_tid[1];
    assign o_head_tag  = w_tag[1];
    assign o_head_data = w_data[1];
    assign o_head_len  = w_len[1];

endmodule

FILE: rtl/core/sorted_timer_queue.sv
// Top level of the sorted timer queue: request decode, tick sequencing and result register.
//
//  channel | dir | word
//  in      | in  | op, tid, delay_ms, handler_tag, user_data, data_len
//  out     | out | kind, exp_tid, exp_tag, exp_data, exp_len, status, pending, last
//
// A start steps through accept, drop of a same-id timer and insert; a cancel through accept
// and shift, or clear when the id is zero; a tick through accept, one pop per expired timer and a closing step.
// Reset (synchronous, active low) empties the row and sets the time to zero.
// A stalled output holds the row; the next word is taken once the current one is done.
module sorted_timer_queue #(
    parameter int unsigned TIMER_SLOTS = stq_pkg::TimerSlots,
    parameter int unsigned DATA_BYTES  = stq_pkg::DataBytes,
    parameter int unsigned TIME_BITS   = stq_pkg::TimeBits
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    stq_if.sink   i_in,
    stq_if.source o_out
);
    import stq_pkg::*;

    localparam int unsigned InW  = 2 + TidW + 32 + TagW + DataW + LenW;
    localparam int unsigned OutW = 1 + TidW + TagW + DataW + LenW + 2 + PendW + 1;
    localparam int unsigned CntW = $clog2(TIMER_SLOTS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPLY,
        S_TICK,
        S_OUT
    } t_state;

    t_state                r_state;
    logic [TIME_BITS-1:0]  r_now;
    logic [CntW-1:0]       r_count;
    logic [1:0]            r_op;
    logic [TidW-1:0]       r_tid;
    logic [31:0]           r_dly;
    logic [TagW-1:0]       r_tag;
    logic [DataW-1:0]      r_data;
    logic [LenW-1:0]       r_len;
    logic                  r_ovalid;
    logic [OutW-1:0]       r_oword;
    logic                  r_tick_more;

    t_cell_cmd             w_cmd;
    logic                  w_hit;
    logic                  w_due;
    logic [TidW-1:0]       w_htid;
    logic [TagW-1:0]       w_htag;
    logic [DataW-1:0]      w_hdata;
    logic [LenW-1:0]       w_hlen;
    logic [TIME_BITS:0]    w_sum;
    logic [TIME_BITS-1:0]  w_exp;
    t_status               w_st;
    logic [CntW-1:0]       w_room;
    logic                  w_ofree;
    logic                  w_oload;
    logic [PendW-1:0]      w_pend_after;

    assign w_ofree = !r_ovalid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && w_ofree;

    // The output register is loaded on every status word and on each tick step that pops or closes a run.
    assign w_oload = (r_state == S_APPLY) ||
                     ((r_state == S_TICK) && w_ofree && (w_due || r_tick_more));

    // Saturating expiry sum.
    assign w_sum = {1'b0, r_now} + {{(TIME_BITS - 30){1'b0}}, r_dly[30:0]};
    assign w_exp = w_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : w_sum[TIME_BITS-1:0];

    // Start checks, in order delay, length, room.
    assign w_room = r_count - {{(CntW-1){1'b0}}, w_hit};
    always_comb begin
        if (r_dly == 32'd0 || r_dly[31]) begin
            w_st = ST_BAD_DLY;
        end else if (r_len > LenW'(DATA_BYTES)) begin
            w_st = ST_LONG;
        end else if (w_room >= CntW'(TIMER_SLOTS)) begin
            w_st = ST_FULL;
        end else begin
            w_st = ST_OK;
        end
    end

    // Row command for this cycle.
    always_comb begin
        w_cmd = CC_HOLD;
        case (r_state)
            S_IDLE: begin
                if (r_op == OP_START && w_st == ST_OK && r_ovalid == 1'b0) begin
                    w_cmd = CC_HOLD;
                end
            end
            S_APPLY: begin
                if (r_op == OP_START) begin
                    w_cmd = (w_st == ST_OK) ? CC_INSERT : CC_HOLD;
                end else if (r_op == OP_CANCEL) begin
                    w_cmd = (r_tid == '0) ? CC_CLEAR : CC_REMOVE_ID;
                end
            end
            S_OUT: begin
                if (w_hit && r_op == OP_START && w_st == ST_OK) begin
                    w_cmd = CC_REMOVE_ID;
                end
            end
            S_TICK: begin
                if (w_ofree && w_due) begin
                    w_cmd = CC_POP;
                end
            end
            default: w_cmd = CC_HOLD;
        endcase
    end

    stq_row #(.TIMER_SLOTS(TIMER_SLOTS), .TIME_BITS(TIME_BITS)) u_row (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_exp      (w_exp),
        .i_tid      (r_tid),
        .i_tag      (r_tag),
        .i_data     (r_data & byte_mask(r_len)),
        .i_len      (r_len),
        .i_now      (r_now),
        .o_any_hit  (w_hit),
        .o_head_due (w_due),
        .o_head_tid (w_htid),
        .o_head_tag (w_htag),
        .o_head_data(w_hdata),
        .o_head_len (w_hlen)
    );

    assign w_pend_after = PendW'(r_count - CntW'(1));

    // Sequencer: S_OUT removes a same-id timer first, S_APPLY then inserts or cancels.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_now       <= '0;
            r_count     <= '0;
            r_ovalid    <= 1'b0;
            r_op        <= OP_NONE;
            r_tick_more <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready && !w_oload) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        {r_op, r_tid, r_dly, r_tag, r_data, r_len} <= i_in.data;
                        case (t_op'(i_in.data[InW-1 -: 2]))
                            OP_START:  r_state <= S_OUT;
                            OP_CANCEL: r_state <= S_APPLY;
                            OP_TICK: begin
                                r_now   <= r_now + TIME_BITS'(1);
                                r_state <= S_TICK;
                            end
                            default:   r_state <= S_IDLE;
                        endcase
                    end
                end
                S_OUT: begin
                    // Drop any same-id timer when the start will succeed.
                    if (w_hit && w_st == ST_OK) begin
                        r_count <= r_count - CntW'(1);
                    end
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    if (r_op == OP_START) begin
                        if (w_st == ST_OK) begin
                            r_count <= r_count + CntW'(1);
                        end
                        r_oword <= {1'b0, r_tid, TagW'(0), DataW'(0), LenW'(0), w_st,
                                    PendW'(r_count + CntW'(w_st == ST_OK)), 1'b1};
                    end else begin
                        if (r_tid == '0) begin
                            r_count <= '0;
                            r_oword <= {1'b0, r_tid, TagW'(0), DataW'(0), LenW'(0), ST_OK,
                                        PendW'(0), 1'b1};
                        end else begin
                            r_count <= r_count - CntW'(w_hit);
                            r_oword <= {1'b0, r_tid, TagW'(0), DataW'(0), LenW'(0), ST_OK,
                                        PendW'(r_count - CntW'(w_hit)), 1'b1};
                        end
                    end
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_TICK: begin
                    if (w_ofree) begin
                        if (w_due) begin
                            r_count  <= r_count - CntW'(1);
                            r_ovalid <= 1'b1;
                            r_oword  <= {1'b1, w_htid, w_htag, w_hdata, w_hlen, ST_OK,
                                         w_pend_after, 1'b0};
                            r_tick_more <= 1'b1;
                        end else begin
                            // Mark the previous expired word as the last one.
                            if (r_tick_more) begin
                                r_ovalid    <= 1'b1;
                                r_oword[0]  <= 1'b1;
                            end
                            r_tick_more <= 1'b0;
                            r_state     <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Hold an expired word until we know whether another timer follows.
    assign o_out.valid = r_ovalid && !(r_state == S_TICK && !r_oword[0] && !w_due);
    assign o_out.data  = r_oword;

    property p_count_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_count <= CntW'(TIMER_SLOTS);
    endproperty
    a_count_bound: assert property (p_count_bound) else $error("timer count overflow");

    property p_ready_idle;
        @(posedge i_clk) disable iff (!i_rst_n) i_in.ready |-> r_state == S_IDLE;
    endproperty
    a_ready_idle: assert property (p_ready_idle) else $error("ready outside idle");

    property p_pop_due;
        @(posedge i_clk) disable iff (!i_rst_n) w_cmd == CC_POP |-> r_count != '0;
    endproperty
    a_pop_due: assert property (p_pop_due) else $error("pop from empty row");

endmodule
